@@ rtl/rvg_pkg.sv @@
// ----------------------------------------------------------------------------
// rvg_pkg
// Shared types and constants for the rollback version guard.
// ----------------------------------------------------------------------------
package rvg_pkg;

  localparam int SV_W   = 16;
  localparam int KG_W   = 8;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [SV_W-1:0] SV_MAX    = 16'hFFFE;
  localparam logic [KG_W-1:0] KGC_RESET = 8'hFF;

  // Word index of the key generation count register.
  localparam logic REG_KGC = 1'b0;

  typedef enum logic [1:0] {
    MODE_CHECK  = 2'd0,
    MODE_COMMIT = 2'd1,
    MODE_LOAD   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SV_BAD = 2'd1,
    ST_KG_BAD = 2'd2,
    ST_RSVD   = 2'd3
  } status_t;

  // Per-kind flags from a history tracker.
  typedef struct packed {
    logic floor_ok;
    logic changed;
  } track_flags_t;

endpackage

@@ rtl/rvg_in_if.sv @@
// ----------------------------------------------------------------------------
// rvg_in_if
// Input channel: one request beat with mode and version values.
// ----------------------------------------------------------------------------
interface rvg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] image_version;
  logic [7:0]  image_generation;
  logic [15:0] loaded_runner_up_security_version;
  logic [7:0]  loaded_runner_up_key_generation;

  modport source (
    output valid, mode, image_version, image_generation,
           loaded_runner_up_security_version, loaded_runner_up_key_generation,
    input  ready
  );
  modport sink (
    input  valid, mode, image_version, image_generation,
           loaded_runner_up_security_version, loaded_runner_up_key_generation,
    output ready
  );
endinterface

@@ rtl/rvg_out_if.sv @@
// ----------------------------------------------------------------------------
// rvg_out_if
// Result channel: status, change flags and the history after the beat.
// ----------------------------------------------------------------------------
interface rvg_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        version_changed;
  logic        generation_changed;
  logic [15:0] reported_top_version;
  logic [15:0] reported_runner_up_version;
  logic [7:0]  reported_top_generation;
  logic [7:0]  reported_runner_up_generation;

  modport source (
    output valid, status, version_changed, generation_changed,
           reported_top_version, reported_runner_up_version,
           reported_top_generation, reported_runner_up_generation,
    input  ready
  );
  modport sink (
    input  valid, status, version_changed, generation_changed,
           reported_top_version, reported_runner_up_version,
           reported_top_generation, reported_runner_up_generation,
    output ready
  );
endinterface

@@ rtl/rvg_cfg.sv @@
// ----------------------------------------------------------------------------
// rvg_cfg
// APB register file holding the key generation count.
// ----------------------------------------------------------------------------
module rvg_cfg
  import rvg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [KG_W-1:0]   key_generation_count
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_KGC);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_generation_count <= KGC_RESET;
    end else if (wr_en) begin
      key_generation_count <= pwdata[KG_W-1:0];
    end
  end

  always_comb begin
    if (paddr[ADDR_W-1] == REG_KGC) begin
      prdata = {{(DATA_W-KG_W){1'b0}}, key_generation_count};
    end else begin
      prdata = '0;
    end
  end

endmodule

@@ rtl/rvg_track.sv @@
// ----------------------------------------------------------------------------
// rvg_track
// Top-two history for one kind of value: floor check and next state.
// ----------------------------------------------------------------------------
module rvg_track
  import rvg_pkg::*;
#(
  parameter int W = 16
) (
  input  mode_t          mode,
  input  logic [W-1:0]   value,
  input  logic [W-1:0]   loaded_second,
  input  logic [W-1:0]   top,
  input  logic [W-1:0]   second,
  output logic [W-1:0]   top_next,
  output logic [W-1:0]   second_next,
  output track_flags_t   flags
);

  logic         top_uninit;
  logic         second_uninit;
  logic [W-1:0] floor_val;
  logic         fold_chg;
  logic [W-1:0] fold_top;
  logic [W-1:0] fold_second;

  assign top_uninit    = (top == {W{1'b1}});
  assign second_uninit = (second == {W{1'b1}});
  assign floor_val     = (top < second) ? top : second;

  always_comb begin
    fold_top    = top;
    fold_second = second;
    fold_chg    = 1'b0;
    if (top_uninit) begin
      fold_top = value;
      fold_chg = 1'b1;
    end else if (value > top) begin
      fold_second = top;
      fold_top    = value;
      fold_chg    = 1'b1;
    end else if (second_uninit) begin
      if (value < top) begin
        fold_second = value;
        fold_chg    = 1'b1;
      end
    end else if (value > second && value < top) begin
      fold_second = value;
      fold_chg    = 1'b1;
    end
  end

  always_comb begin
    flags.floor_ok = top_uninit || second_uninit || (value >= floor_val);
    flags.changed  = 1'b0;
    top_next       = top;
    second_next    = second;
    case (mode)
      MODE_COMMIT: begin
        top_next      = fold_top;
        second_next   = fold_second;
        flags.changed = fold_chg;
      end
      MODE_LOAD: begin
        top_next    = value;
        second_next = loaded_second;
      end
      default: begin
        top_next    = top;
        second_next = second;
      end
    endcase
  end

endmodule

@@ rtl/rollback_version_guard.sv @@
// ----------------------------------------------------------------------------
// rollback_version_guard
// Anti-rollback guard keeping the top two security versions and key
// generations; checks, commits and restores them one beat at a time.
// ----------------------------------------------------------------------------
// One request beat per clock is sustained while result beats are taken; a
// stall on the result channel holds the beat in the input register. A beat
// lands in the input register, passes the floor checks and top-two update in
// compare logic, and its result is loaded into the output register. The
// history registers update as the beat moves to the output stage, so the next
// beat already sees it. Every beat yields exactly one result beat. The key
// generation count at byte address 0 is to be written over APB by the user
// only while no beat is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rollback_version_guard
  import rvg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  rvg_in_if.sink            item,
  rvg_out_if.source         result
);

  logic [KG_W-1:0] key_generation_count;

  // Input stage
  logic            in_valid;
  mode_t           in_mode;
  logic [SV_W-1:0] in_sv;
  logic [KG_W-1:0] in_kg;
  logic [SV_W-1:0] in_sv2;
  logic [KG_W-1:0] in_kg2;

  // History
  logic [SV_W-1:0] top_sv;
  logic [SV_W-1:0] second_sv;
  logic [KG_W-1:0] top_kg;
  logic [KG_W-1:0] second_kg;
  logic [SV_W-1:0] top_sv_next;
  logic [SV_W-1:0] second_sv_next;
  logic [KG_W-1:0] top_kg_next;
  logic [KG_W-1:0] second_kg_next;
  track_flags_t    sv_flags;
  track_flags_t    kg_flags;

  // Output stage
  logic            out_valid;
  status_t         out_status;
  logic            out_vchg;
  logic            out_gchg;
  logic [SV_W-1:0] out_top_sv;
  logic [SV_W-1:0] out_second_sv;
  logic [KG_W-1:0] out_top_kg;
  logic [KG_W-1:0] out_second_kg;

  status_t status_next;
  logic    advance;
  logic    fire;

  rvg_cfg u_cfg (
    .clk                  (clk),
    .rst                  (rst),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .key_generation_count (key_generation_count)
  );

  rvg_track #(.W(SV_W)) u_track_sv (
    .mode          (in_mode),
    .value         (in_sv),
    .loaded_second (in_sv2),
    .top           (top_sv),
    .second        (second_sv),
    .top_next      (top_sv_next),
    .second_next   (second_sv_next),
    .flags         (sv_flags)
  );

  rvg_track #(.W(KG_W)) u_track_kg (
    .mode          (in_mode),
    .value         (in_kg),
    .loaded_second (in_kg2),
    .top           (top_kg),
    .second        (second_kg),
    .top_next      (top_kg_next),
    .second_next   (second_kg_next),
    .flags         (kg_flags)
  );

  assign advance    = !out_valid || result.ready;
  assign fire       = in_valid && advance;
  assign item.ready = !in_valid || advance;

  // Security version is checked first.
  always_comb begin
    status_next = ST_OK;
    if (in_mode == MODE_CHECK) begin
      if (in_sv > SV_MAX || !sv_flags.floor_ok) begin
        status_next = ST_SV_BAD;
      end else if (in_kg >= key_generation_count || !kg_flags.floor_ok) begin
        status_next = ST_KG_BAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      in_mode <= mode_t'(item.mode);
      in_sv   <= item.image_version;
      in_kg   <= item.image_generation;
      in_sv2  <= item.loaded_runner_up_security_version;
      in_kg2  <= item.loaded_runner_up_key_generation;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_sv    <= '1;
      second_sv <= '1;
      top_kg    <= '1;
      second_kg <= '1;
    end else if (fire) begin
      top_sv    <= top_sv_next;
      second_sv <= second_sv_next;
      top_kg    <= top_kg_next;
      second_kg <= second_kg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status    <= status_next;
      out_vchg      <= sv_flags.changed;
      out_gchg      <= kg_flags.changed;
      out_top_sv    <= top_sv_next;
      out_second_sv <= second_sv_next;
      out_top_kg    <= top_kg_next;
      out_second_kg <= second_kg_next;
    end
  end

  assign result.valid                         = out_valid;
  assign result.status                        = out_status;
  assign result.version_changed               = out_vchg;
  assign result.generation_changed            = out_gchg;
  assign result.reported_top_version          = out_top_sv;
  assign result.reported_runner_up_version    = out_second_sv;
  assign result.reported_top_generation       = out_top_kg;
  assign result.reported_runner_up_generation = out_second_kg;

endmodule

@@ rtl/rvg_checker.sv @@
// ----------------------------------------------------------------------------
// rvg_checker
// Port-level checks for the rollback version guard, bound to the top level.
// ----------------------------------------------------------------------------
module rvg_checker
  import rvg_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        pready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic        version_changed,
  input logic        generation_changed,
  input logic [15:0] reported_top_version
);

  // No result right after reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result beat stays and holds its status and top version.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status)
      && $stable(reported_top_version))
    else $error("stalled result changed");

  // Change flags only come from commits, which always report OK.
  a_flags_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (version_changed || generation_changed) |-> status == ST_OK)
    else $error("change flag with failing status");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != ST_RSVD)
    else $error("reserved status code");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind rollback_version_guard rvg_checker u_rvg_checker (
  .clk                  (clk),
  .rst                  (rst),
  .pready               (pready),
  .out_valid            (result.valid),
  .out_ready            (result.ready),
  .status               (result.status),
  .version_changed      (result.version_changed),
  .generation_changed   (result.generation_changed),
  .reported_top_version (result.reported_top_version)
);

@@ verif/rvg_guard_checker.sv @@
// ----------------------------------------------------------------------------
// rvg_guard_checker
// Watches the request, result and APB ports of the rollback version guard.
// It keeps its own copy of the version and generation history and of the
// key generation count, predicts one result per accepted request and
// compares each result beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module rvg_guard_checker
  import rvg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  rvg_in_if                 item,
  rvg_out_if                result,
  output int                fail_count,
  output int                outstanding,
  output int                compared,
  output int                version_rejects,
  output int                generation_rejects,
  output int                history_updates
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ADDR_W-1:0] COUNT_ADDR   = ADDR_W'({REG_KGC, 2'b00});
  localparam logic [SV_W-1:0]   VER_UNSET    = '1;
  localparam logic [KG_W-1:0]   GEN_UNSET    = '1;
  localparam int                REPORT_LIMIT = 10;

  typedef struct packed {
    status_t         status;
    logic            version_changed;
    logic            generation_changed;
    logic [SV_W-1:0] top_version;
    logic [SV_W-1:0] runner_up_version;
    logic [KG_W-1:0] top_generation;
    logic [KG_W-1:0] runner_up_generation;
  } guard_result_t;

  logic [KG_W-1:0] gen_count;
  logic [SV_W-1:0] top_ver;
  logic [SV_W-1:0] second_ver;
  logic [KG_W-1:0] top_gen;
  logic [KG_W-1:0] second_gen;
  guard_result_t   awaited_q[$];
  int              fails;
  int              n_compared;
  int              n_ver_rej;
  int              n_gen_rej;
  int              n_updates;

  // Both kinds share these; generations ride zero-extended in 16 bits.
  function automatic logic meets_floor(logic [15:0] v, top, second, unset);
    if (top == unset || second == unset) return 1'b1;
    return v >= ((top < second) ? top : second);
  endfunction

  function automatic logic fold_top_two(input logic [15:0] v, unset,
                                        inout logic [15:0] top, second);
    if (top == unset) begin
      top = v;
      return 1'b1;
    end
    if (v > top) begin
      second = top;
      top = v;
      return 1'b1;
    end
    if (second == unset) begin
      if (v < top) begin
        second = v;
        return 1'b1;
      end
      return 1'b0;
    end
    if (v > second && v < top) begin
      second = v;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic guard_result_t predict_guard(mode_t mode, logic [SV_W-1:0] ver,
                                                  logic [KG_W-1:0] gen,
                                                  logic [SV_W-1:0] ver2,
                                                  logic [KG_W-1:0] gen2);
    guard_result_t r;
    logic [15:0]   g_top;
    logic [15:0]   g_second;
    r = '0;
    g_top = {8'h00, top_gen};
    g_second = {8'h00, second_gen};
    case (mode)
      MODE_CHECK: begin
        // version decides first, generation only if the version passes
        if (ver > SV_MAX || !meets_floor(ver, top_ver, second_ver, VER_UNSET))
          r.status = ST_SV_BAD;
        else if (gen >= gen_count ||
                 !meets_floor({8'h00, gen}, g_top, g_second, {8'h00, GEN_UNSET}))
          r.status = ST_KG_BAD;
      end
      MODE_COMMIT: begin
        r.version_changed = fold_top_two(ver, VER_UNSET, top_ver, second_ver);
        r.generation_changed = fold_top_two({8'h00, gen}, {8'h00, GEN_UNSET},
                                            g_top, g_second);
        top_gen = g_top[KG_W-1:0];
        second_gen = g_second[KG_W-1:0];
      end
      MODE_LOAD: begin
        top_ver = ver;
        second_ver = ver2;
        top_gen = gen;
        second_gen = gen2;
      end
      default: ;
    endcase
    r.top_version = top_ver;
    r.runner_up_version = second_ver;
    r.top_generation = top_gen;
    r.runner_up_generation = second_gen;
    return r;
  endfunction

  always @(posedge clk) begin
    guard_result_t got;
    guard_result_t want;
    logic [6:0]    diff;
    if (rst) begin
      gen_count = KGC_RESET;
      top_ver = VER_UNSET;
      second_ver = VER_UNSET;
      top_gen = GEN_UNSET;
      second_gen = GEN_UNSET;
      awaited_q.delete();
    end else begin
      if (result.valid && result.ready) begin
        got.status = status_t'(result.status);
        got.version_changed = result.version_changed;
        got.generation_changed = result.generation_changed;
        got.top_version = result.reported_top_version;
        got.runner_up_version = result.reported_runner_up_version;
        got.top_generation = result.reported_top_generation;
        got.runner_up_generation = result.reported_runner_up_generation;
        if (awaited_q.size() == 0) begin
          if (fails < REPORT_LIMIT)
            $display("%t: result beat with nothing awaited (status=%0d top=%h)",
                     $time, got.status, got.top_version);
          fails++;
        end else begin
          want = awaited_q.pop_front();
          n_compared++;
          diff = {got.status !== want.status,
                  got.version_changed !== want.version_changed,
                  got.generation_changed !== want.generation_changed,
                  got.top_version !== want.top_version,
                  got.runner_up_version !== want.runner_up_version,
                  got.top_generation !== want.top_generation,
                  got.runner_up_generation !== want.runner_up_generation};
          if (diff != 0) begin
            if (fails < REPORT_LIMIT) begin
              $display("%t: result %0d differs, field mask %b", $time, n_compared, diff);
              $display("  expected status=%0d vchg=%b gchg=%b ver=%h/%h gen=%h/%h",
                       want.status, want.version_changed, want.generation_changed,
                       want.top_version, want.runner_up_version,
                       want.top_generation, want.runner_up_generation);
              $display("  actual   status=%0d vchg=%b gchg=%b ver=%h/%h gen=%h/%h",
                       got.status, got.version_changed, got.generation_changed,
                       got.top_version, got.runner_up_version,
                       got.top_generation, got.runner_up_generation);
            end
            fails++;
          end
          if (want.status == ST_SV_BAD) n_ver_rej++;
          if (want.status == ST_KG_BAD) n_gen_rej++;
          if (want.version_changed || want.generation_changed) n_updates++;
        end
      end
      if (item.valid && item.ready)
        awaited_q.push_back(predict_guard(mode_t'(item.mode), item.image_version,
                                          item.image_generation,
                                          item.loaded_runner_up_security_version,
                                          item.loaded_runner_up_key_generation));
      if (psel && penable && pwrite && pready && paddr == COUNT_ADDR)
        gen_count = pwdata[KG_W-1:0];
    end
    fail_count <= fails;
    outstanding <= awaited_q.size();
    compared <= n_compared;
    version_rejects <= n_ver_rej;
    generation_rejects <= n_gen_rej;
    history_updates <= n_updates;
  end

endmodule

@@ verif/rollback_version_guard_tb.sv @@
// ----------------------------------------------------------------------------
// rollback_version_guard_tb
// Drives the rollback version guard with a directed run through the
// eligibility and top-two update corners, then random checks, commits and
// loads under several key generation counts, with random gaps on both
// channels. A side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module rollback_version_guard_tb
  import rvg_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ADDR_W-1:0] COUNT_ADDR    = ADDR_W'({REG_KGC, 2'b00});
  localparam int                PHASE_BEATS   = 250;
  localparam int                N_PHASES      = 6;
  localparam int                SETTLE_CYCLES = 4;

  typedef struct packed {
    mode_t           mode;
    logic [SV_W-1:0] ver;
    logic [KG_W-1:0] gen;
    logic [SV_W-1:0] ver2;
    logic [KG_W-1:0] gen2;
  } guard_req_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int fail_count;
  int outstanding;
  int compared;
  int version_rejects;
  int generation_rejects;
  int history_updates;

  logic [KG_W-1:0] count_plan [N_PHASES];
  logic [KG_W-1:0] cur_count;
  logic [SV_W-1:0] ver_window;
  logic [KG_W-1:0] gen_window;
  int              beats_by_mode [4];
  int              settings_used;
  int              src_left;
  int              snk_left;
  bit              src_calm;
  bit              snk_calm;

  rvg_in_if  item_ch ();
  rvg_out_if result_ch ();

  rollback_version_guard i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (item_ch),
    .result  (result_ch)
  );

  rvg_guard_checker i_checker (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .pready             (pready),
    .item               (item_ch),
    .result             (result_ch),
    .fail_count         (fail_count),
    .outstanding        (outstanding),
    .compared           (compared),
    .version_rejects    (version_rejects),
    .generation_rejects (generation_rejects),
    .history_updates    (history_updates)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("rollback_version_guard_tb: errors");
    $finish;
  end

  // Alternate calm stretches (no waits) with stretches of random waits.
  function automatic int draw_wait(inout int left, inout bit calm);
    if (left == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      left = $urandom_range(20, 60);
    end
    left--;
    if (calm) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic guard_req_t make_request(mode_t m, logic [SV_W-1:0] v,
                                              logic [KG_W-1:0] g,
                                              logic [SV_W-1:0] v2,
                                              logic [KG_W-1:0] g2);
    guard_req_t r;
    r.mode = m;
    r.ver = v;
    r.gen = g;
    r.ver2 = v2;
    r.gen2 = g2;
    return r;
  endfunction

  function automatic logic [SV_W-1:0] pick_version();
    case ($urandom_range(0, 23))
      0: return SV_W'($urandom);
      1: return '0;
      2: return SV_MAX;
      3: return '1;
      default: return ver_window + SV_W'($urandom_range(0, 47));
    endcase
  endfunction

  function automatic logic [KG_W-1:0] pick_generation();
    case ($urandom_range(0, 23))
      0: return KG_W'($urandom);
      1: return '0;
      2: return cur_count;
      3: return cur_count - 8'd1;
      4: return '1;
      default: return gen_window + KG_W'($urandom_range(0, 47));
    endcase
  endfunction

  task automatic write_gen_count(input logic [KG_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= COUNT_ADDR;
    pwdata <= {24'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_count = value;
    settings_used++;
  endtask

  task automatic push_request(input guard_req_t r, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_ch.valid <= 1'b1;
    item_ch.mode <= r.mode;
    item_ch.image_version <= r.ver;
    item_ch.image_generation <= r.gen;
    item_ch.loaded_runner_up_security_version <= r.ver2;
    item_ch.loaded_runner_up_key_generation <= r.gen2;
    do @(posedge clk); while (!item_ch.ready);
    beats_by_mode[int'(r.mode)]++;
  endtask

  // Hold off the request side until every predicted result has come back.
  task automatic settle();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Result side: random stall, then hold ready until a beat goes through.
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      stall = draw_wait(snk_left, snk_calm);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  initial begin
    guard_req_t plan[$];
    guard_req_t r;
    int         done;
    int         pick;
    int         sent_total;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_ch.valid = 1'b0;
    item_ch.mode = MODE_CHECK;
    item_ch.image_version = '0;
    item_ch.image_generation = '0;
    item_ch.loaded_runner_up_security_version = '0;
    item_ch.loaded_runner_up_key_generation = '0;
    cur_count = KGC_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed corners under a small count so the generation limit bites.
    write_gen_count(8'd8);
    plan.push_back(make_request(MODE_CHECK,  16'd0,     8'd0,  16'd0,     8'd0));
    plan.push_back(make_request(MODE_CHECK,  16'hFFFF,  8'd0,  16'd0,     8'd0));
    plan.push_back(make_request(MODE_CHECK,  16'hFFFE,  8'd8,  16'd0,     8'd0));
    plan.push_back(make_request(MODE_CHECK,  16'hFFFF,  8'hFF, 16'd0,     8'd0));
    plan.push_back(make_request(MODE_COMMIT, 16'hFFFF,  8'hFF, 16'd0,     8'd0));
    plan.push_back(make_request(MODE_COMMIT, 16'd100,   8'd5,  16'd0,     8'd0));
    plan.push_back(make_request(MODE_COMMIT, 16'd100,   8'd5,  16'd0,     8'd0));
    plan.push_back(make_request(MODE_COMMIT, 16'd50,    8'd3,  16'd0,     8'd0));
    plan.push_back(make_request(MODE_CHECK,  16'd49,    8'd3,  16'd0,     8'd0));
    plan.push_back(make_request(MODE_CHECK,  16'd50,    8'd2,  16'd0,     8'd0));
    plan.push_back(make_request(MODE_CHECK,  16'd50,    8'd3,  16'd0,     8'd0));
    plan.push_back(make_request(MODE_COMMIT, 16'd200,   8'd7,  16'd0,     8'd0));
    plan.push_back(make_request(MODE_COMMIT, 16'd150,   8'd6,  16'd0,     8'd0));
    plan.push_back(make_request(MODE_COMMIT, 16'd120,   8'd4,  16'd0,     8'd0));
    plan.push_back(make_request(MODE_COMMIT, 16'd200,   8'd7,  16'd0,     8'd0));
    plan.push_back(make_request(MODE_CHECK,  16'hFFFE,  8'd7,  16'd0,     8'd0));
    plan.push_back(make_request(MODE_CHECK,  16'd150,   8'd8,  16'd0,     8'd0));
    plan.push_back(make_request(MODE_NONE,   16'hFFFF,  8'hFF, 16'hFFFF,  8'hFF));
    plan.push_back(make_request(MODE_LOAD,   16'd10,    8'hFF, 16'hFFFF,  8'd2));
    plan.push_back(make_request(MODE_CHECK,  16'd0,     8'd0,  16'd0,     8'd0));
    plan.push_back(make_request(MODE_LOAD,   16'd5,     8'd0,  16'd300,   8'd9));
    plan.push_back(make_request(MODE_CHECK,  16'd4,     8'd0,  16'd0,     8'd0));
    plan.push_back(make_request(MODE_CHECK,  16'd5,     8'd0,  16'd0,     8'd0));
    plan.push_back(make_request(MODE_COMMIT, 16'd0,     8'd0,  16'd0,     8'd0));
    plan.push_back(make_request(MODE_LOAD,   16'd0,     8'd0,  16'd0,     8'd0));
    plan.push_back(make_request(MODE_COMMIT, 16'hFFFF,  8'hFF, 16'd0,     8'd0));
    plan.push_back(make_request(MODE_CHECK,  16'hFFFE,  8'd7,  16'd0,     8'd0));
    foreach (plan[i]) push_request(plan[i], draw_wait(src_left, src_calm));
    settle();

    count_plan = '{8'd255, 8'd1, 8'd0, 8'($urandom_range(2, 254)), 8'd128, 8'd255};
    sent_total = 0;
    for (int phase = 0; phase < N_PHASES; phase++) begin
      write_gen_count(count_plan[phase]);
      gen_window = (cur_count > 8'd32) ? 8'($urandom_range(0, int'(cur_count) - 32)) : 8'd0;
      done = 0;
      while (done < PHASE_BEATS) begin
        // Drift the version window now and then so history keeps moving.
        if (sent_total % 128 == 0) ver_window = 16'($urandom_range(0, 16'hFFD0));
        pick = $urandom_range(0, 99);
        r.mode = (pick < 45) ? MODE_CHECK :
                 (pick < 80) ? MODE_COMMIT :
                 (pick < 96) ? MODE_LOAD : MODE_NONE;
        r.ver = pick_version();
        r.gen = pick_generation();
        if (r.mode == MODE_LOAD) begin
          r.ver2 = pick_version();
          r.gen2 = pick_generation();
        end else begin
          r.ver2 = 16'($urandom);
          r.gen2 = 8'($urandom);
        end
        push_request(r, draw_wait(src_left, src_calm));
        sent_total++;
        if (r.mode != MODE_NONE) done++;
        if ((r.mode != MODE_NONE && done == PHASE_BEATS / 2) || $urandom_range(0, 299) == 0)
          settle();
      end
      settle();
    end

    $display("covered %0d checks, %0d commits, %0d loads, %0d undefined-mode beats, %0d counts",
             beats_by_mode[int'(MODE_CHECK)], beats_by_mode[int'(MODE_COMMIT)],
             beats_by_mode[int'(MODE_LOAD)], beats_by_mode[int'(MODE_NONE)], settings_used);
    $display("compared %0d results: %0d version rejects, %0d generation rejects, %0d updates",
             compared, version_rejects, generation_rejects, history_updates);
    if (fail_count == 0 && outstanding == 0) begin
      $display("rollback_version_guard_tb: clean");
    end else begin
      $display("rollback_version_guard_tb: errors");
    end
    $finish;
  end

endmodule
